@@ rtl/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// mct_pkg
// shared types and codes for the multipage completion tracker
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int MASK_W   = 64;
	localparam int TOTAL_W  = 7;
	localparam int INDEX_W  = 6;
	localparam int RETRY_W  = 5;
	localparam int LIMIT_W  = 4;
	localparam int KIND_W   = 2;
	localparam int CLS_W    = 2;

	// event kinds
	localparam logic [KIND_W-1:0] EV_ISSUE     = 2'd0;
	localparam logic [KIND_W-1:0] EV_DONE_OK   = 2'd1;
	localparam logic [KIND_W-1:0] EV_DONE_FAIL = 2'd2;
	localparam logic [KIND_W-1:0] EV_REJECT    = 2'd3;

	// request classes
	localparam logic [CLS_W-1:0] CLS_START  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_REJECT = 2'd1;
	localparam logic [CLS_W-1:0] CLS_RESULT = 2'd2;

	localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 4'd3;

	typedef struct packed {
		logic [CLS_W-1:0]   cls;
		logic [TOTAL_W-1:0] page_total;
		logic [INDEX_W-1:0] page_index;
		logic               page_ok;
	} req_t;

endpackage

@@ rtl/mct_front.sv @@
// ----------------------------------------------------------------------------
// mct_front
// accepts requests and classifies them as start, reject or page result
// ----------------------------------------------------------------------------
module mct_front import mct_pkg::*; #(
	parameter int MAX_PAGES = 64
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [TOTAL_W-1:0] page_total,
	input  logic [INDEX_W-1:0] page_index,
	input  logic               page_ok,
	output logic               push,
	output req_t               push_req,
	input  logic               q_full
);

	logic total_ok;

	assign total_ok = (page_total != '0) && (page_total <= TOTAL_W'(MAX_PAGES));

	always_comb begin
		push_req.page_total = page_total;
		push_req.page_index = page_index;
		push_req.page_ok    = page_ok;
		if (cmd) begin
			push_req.cls = CLS_RESULT;
		end else if (total_ok) begin
			push_req.cls = CLS_START;
		end else begin
			push_req.cls = CLS_REJECT;
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

@@ rtl/mct_queue.sv @@
// ----------------------------------------------------------------------------
// mct_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module mct_queue import mct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output req_t q_req
);

	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_req   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/mct_back.sv @@
// ----------------------------------------------------------------------------
// mct_back
// command state, page bookkeeping, retry decision and output register
// ----------------------------------------------------------------------------
module mct_back import mct_pkg::*; #(
	parameter int MAX_PAGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	input  logic               q_valid,
	input  req_t               q_req,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  event_kind,
	output logic [MASK_W-1:0]  page_mask,
	output logic [RETRY_W-1:0] retries_used
);

	localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	logic [MAX_PAGES-1:0] pend_q;
	logic [TOTAL_W-1:0]   proc_q;
	logic [TOTAL_W-1:0]   succ_q;
	logic [RETRY_W-1:0]   retry_q;
	logic [TOTAL_W-1:0]   total_q;
	logic                 busy_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [MASK_W-1:0]    mask_q;
	logic [RETRY_W-1:0]   retries_q;

	logic [MAX_PAGES-1:0] start_mask;
	logic [MAX_PAGES-1:0] pend_clr;
	logic [MAX_PAGES-1:0] bit_sel;
	logic                 hit;
	logic [TOTAL_W-1:0]   succ_n;
	logic [TOTAL_W-1:0]   proc_n;
	logic [RETRY_W-1:0]   retry_n;
	logic                 round_done;
	logic                 retry_ok;
	logic                 emit;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		for (int i = 0; i < MAX_PAGES; i++) begin
			start_mask[i] = (TOTAL_W'(i) < q_req.page_total);
			bit_sel[i]    = (IDX_W'(i) == q_req.page_index[IDX_W-1:0]);
		end
	end

	assign hit        = busy_q && (TOTAL_W'(q_req.page_index) < total_q)
		&& |(pend_q & bit_sel);
	assign pend_clr   = q_req.page_ok ? (pend_q & ~bit_sel) : pend_q;
	assign succ_n     = q_req.page_ok ? succ_q + 7'd1 : succ_q;
	assign proc_n     = proc_q + 7'd1;
	assign retry_n    = retry_q + 5'd1;
	assign round_done = (proc_n == total_q);
	assign retry_ok   = (retry_n <= RETRY_W'(limit_q));
	assign emit       = pop && ((q_req.cls == CLS_START) || (q_req.cls == CLS_REJECT)
		|| ((q_req.cls == CLS_RESULT) && hit && round_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			proc_q      <= '0;
			succ_q      <= '0;
			retry_q     <= '0;
			total_q     <= '0;
			busy_q      <= 1'b0;
			limit_q     <= RETRY_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			out_valid_q <= emit || (out_valid_q && out_stall);
			if (pop) begin
				unique case (q_req.cls)
					CLS_REJECT: begin
						pend_q  <= '0;
						proc_q  <= '0;
						succ_q  <= '0;
						retry_q <= '0;
						total_q <= '0;
						busy_q  <= 1'b0;
					end
					CLS_START: begin
						pend_q  <= start_mask;
						proc_q  <= '0;
						succ_q  <= '0;
						retry_q <= '0;
						total_q <= q_req.page_total;
						busy_q  <= 1'b1;
					end
					CLS_RESULT: begin
						if (hit) begin
							pend_q <= pend_clr;
							succ_q <= succ_n;
							proc_q <= (round_done && (pend_clr != '0) && retry_ok) ?
								succ_n : proc_n;
							if (round_done) begin
								if (pend_clr == '0) begin
									busy_q <= 1'b0;
								end else begin
									retry_q <= retry_n;
									if (!retry_ok) begin
										busy_q <= 1'b0;
									end
								end
							end
						end
					end
					default: begin
						busy_q <= busy_q;
					end
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (q_req.cls)
				CLS_START: begin
					kind_q    <= EV_ISSUE;
					mask_q    <= MASK_W'(start_mask);
					retries_q <= '0;
				end
				CLS_RESULT: begin
					if (pend_clr == '0) begin
						kind_q    <= EV_DONE_OK;
						mask_q    <= '0;
						retries_q <= retry_q;
					end else if (retry_ok) begin
						kind_q    <= EV_ISSUE;
						mask_q    <= MASK_W'(pend_clr);
						retries_q <= retry_n;
					end else begin
						kind_q    <= EV_DONE_FAIL;
						mask_q    <= '0;
						retries_q <= retry_n;
					end
				end
				default: begin
					kind_q    <= EV_REJECT;
					mask_q    <= '0;
					retries_q <= '0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign page_mask    = mask_q;
	assign retries_used = retries_q;

endmodule

@@ rtl/multipage_completion_tracker_top.sv @@
// ----------------------------------------------------------------------------
// multipage_completion_tracker_top
// completion tracker for one multi-page flash command
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | cmd, page_total, page_index, page_ok
//   out      | out_valid/out_stall| event_kind, page_mask, retries_used
//   cfg      | cfg_we             | cfg_wdata (retry limit)
//
// one request per cycle sustained while out_stall is low; a request is classified
// on entry, waits in a two-entry queue and, once popped, updates the command
// state, where its result lands in the output register
// a held output register stops the queue from draining; in_stall rises only
// when the queue is full
// reset clears the command state and loads the retry limit with 3
// ----------------------------------------------------------------------------
module multipage_completion_tracker_top import mct_pkg::*; #(
	parameter int MAX_PAGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [TOTAL_W-1:0] page_total,
	input  logic [INDEX_W-1:0] page_index,
	input  logic               page_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [KIND_W-1:0]  event_kind,
	output logic [MASK_W-1:0]  page_mask,
	output logic [RETRY_W-1:0] retries_used
);

	logic push;
	req_t push_req;
	logic q_full;
	logic pop;
	logic q_valid;
	req_t q_req;

	mct_front #(.MAX_PAGES(MAX_PAGES)) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.page_total (page_total),
		.page_index (page_index),
		.page_ok    (page_ok),
		.push       (push),
		.push_req   (push_req),
		.q_full     (q_full)
	);

	mct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_req    (q_req)
	);

	mct_back #(.MAX_PAGES(MAX_PAGES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.page_mask    (page_mask),
		.retries_used (retries_used)
	);

endmodule
